[rtl/core/rdc_pkg.sv]
// Package for the radix digit converter: sizes, radix limits and sequencer states.
// It depends on nothing; the top level and the divider of the converter import it.
package rdc_pkg;

   // Width of the value to convert and the depth of the digit stack.
   localparam int VALUE_BITS  = 31;
   localparam int MAX_DIGITS  = 32;
   localparam int DIGIT_W     = 6;

   // Derived widths.
   localparam int STEP_CNT_W  = $clog2(VALUE_BITS);
   localparam int ADDR_W      = $clog2(MAX_DIGITS);
   localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

   // Radix limits and reset value.
   localparam logic [DIGIT_W-1:0] RADIX_MIN   = DIGIT_W'(2);
   localparam logic [DIGIT_W-1:0] RADIX_MAX   = DIGIT_W'(36);
   localparam logic [DIGIT_W-1:0] RADIX_RESET = DIGIT_W'(10);

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_READ,
      ST_EMIT
   } seq_state_type;

   // Clamp a raw radix into the legal range.
   function automatic logic [DIGIT_W-1:0] clamp_radix(input logic [DIGIT_W-1:0] raw);
      logic [DIGIT_W-1:0] r;
      r = raw;
      if (r < RADIX_MIN) begin
         r = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         r = RADIX_MAX;
      end
      return r;
   endfunction

endpackage

[rtl/core/radix_digit_converter_core.sv]
// Top level of the radix digit converter: sequencer, radix register and result register.
// It depends on rdc_pkg, rdc_divider and rdc_ram.
//
//  Channel   Ports                               Direction  Handshake
//  request   req_valid req_ready req_value      in         valid/ready
//  response  rsp_valid rsp_ready rsp_digit      out        valid/ready
//            rsp_last
//  config    csr_write_en csr_write_data        in         write enable, no wait
//
// Each digit takes one division in the shared serial divider.
// Each digit is then emitted by a stack read (ST_READ) and a result load (ST_EMIT);
// a stalled consumer holds the sequencer.
// The next item is taken as soon as the last digit sits in the result register.
// Reset is synchronous and restores the radix to 10; the digit stack needs no clearing.
module radix_digit_converter_core
   import rdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DIGIT_W-1:0]    rsp_digit,
   output logic                  rsp_last,
   input  logic                  csr_write_en,
   input  logic [DIGIT_W-1:0]    csr_write_data
);

   seq_state_type          state_ff, state_in;
   logic [DIGIT_W-1:0]     radix_ff, radix_in;
   logic [DIGIT_W-1:0]     eff_radix_ff, eff_radix_in;
   logic [VALUE_BITS-1:0]  quot_ff, quot_in;
   logic [DIGIT_CNT_W-1:0] count_ff, count_in;
   logic [DIGIT_CNT_W-1:0] emit_ff, emit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0]     rsp_digit_ff, rsp_digit_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   div_start;
   logic                   div_done;
   logic [VALUE_BITS-1:0]  div_quotient;
   logic [DIGIT_W-1:0]     div_remainder;
   logic                   stack_wr_en;
   logic [ADDR_W-1:0]      stack_wr_addr;
   logic [ADDR_W-1:0]      stack_rd_addr;
   logic [DIGIT_W-1:0]     stack_rd_data;
   logic [DIGIT_CNT_W-1:0] count_next;
   logic [DIGIT_CNT_W-1:0] emit_next;
   logic                   slot_free;

   localparam logic [DIGIT_CNT_W-1:0] MaxDigitsC = DIGIT_CNT_W'(MAX_DIGITS);

   // Shared serial divider.
   rdc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (quot_ff),
      .divisor   (eff_radix_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // Digit stack, least significant digit at address zero.
   rdc_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_wr_addr),
      .wr_data (div_remainder),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   assign count_next    = count_ff + 1'b1;
   assign emit_next     = emit_ff + 1'b1;
   assign stack_wr_addr = count_ff[ADDR_W-1:0];
   assign stack_rd_addr = ADDR_W'(count_ff - emit_ff - 1'b1);
   assign slot_free     = !rsp_valid_ff || rsp_ready;

   // Sequencer: divide until the quotient is zero or the stack is full, then read the stack back downward.
   always_comb begin
      state_in     = state_ff;
      radix_in     = csr_write_en ? csr_write_data : radix_ff;
      eff_radix_in = eff_radix_ff;
      quot_in      = quot_ff;
      count_in     = count_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_digit_in = rsp_digit_ff;
      rsp_last_in  = rsp_last_ff;
      req_ready    = 1'b0;
      div_start    = 1'b0;
      stack_wr_en  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               quot_in      = req_value;
               eff_radix_in = clamp_radix(radix_ff);
               count_in     = '0;
               state_in     = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               stack_wr_en = 1'b1;
               quot_in     = div_quotient;
               count_in    = count_next;
               if (div_quotient != '0 && count_next < MaxDigitsC) begin
                  state_in = ST_DIV_START;
               end else begin
                  emit_in  = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = stack_rd_data;
               rsp_last_in  = emit_next == count_ff;
               emit_in      = emit_next;
               state_in     = (emit_next == count_ff) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         count_ff     <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         count_ff     <= count_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      eff_radix_ff <= eff_radix_in;
      quot_ff      <= quot_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_digit = rsp_digit_ff;
   assign rsp_last  = rsp_last_ff;

   // The digit count never exceeds the stack depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= MaxDigitsC)
      else $error("digit count beyond stack depth");

   // A division result only arrives while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset) div_done |-> state_ff == ST_DIV_WAIT)
      else $error("division finished outside the wait state");

   // While emitting, the read pointer stays inside the digits of this item.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT || state_ff == ST_READ) |-> emit_ff < count_ff)
      else $error("emit index past digit count");

   // The last digit of an item returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free && emit_next == count_ff) |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after last digit");

endmodule

[rtl/core/rdc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing.
module rdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/rdc_divider.sv]
// Restoring serial divider: one quotient bit per cycle, VALUE_BITS steps per division.
// It depends on rdc_pkg.
module rdc_divider
   import rdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [DIGIT_W-1:0]    divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [DIGIT_W-1:0]    remainder
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [DIGIT_W-1:0]    divisor_ff, divisor_in;
   logic [DIGIT_W:0]      rem_shift;
   logic                  fits;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      rem_shift  = {rem_ff, quot_ff[VALUE_BITS-1]};
      fits       = rem_shift >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = STEP_CNT_W'(VALUE_BITS - 1);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? DIGIT_W'(rem_shift - {1'b0, divisor_ff})
                        : rem_shift[DIGIT_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

   // The remainder handed out is always below the divisor.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> rem_ff < divisor_ff)
      else $error("divider remainder not below divisor");

   // A completed division never overlaps a running one.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule
